FILE: src/cpr_pkg.sv
package cpr_pkg;

   localparam int FRAMES     = 64;
   localparam int PAGE_WIDTH = 16;
   localparam int SLOT_W     = $clog2(FRAMES);
   localparam int SIZE_W     = $clog2(FRAMES + 1);
   localparam int CFG_W      = 7;

   localparam logic CFG_ENHANCED_MODE = 1'b0;
   localparam logic CFG_FRAMES_IN_USE = 1'b1;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_VICTIM = 1'b1;

   typedef struct packed {
      logic [PAGE_WIDTH-1:0] page;
      logic                  dirty_bit;
      logic                  use_bit;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      entry_type         wdata;
      logic [SLOT_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic              idle;
      logic              scanning;
      logic [SLOT_W-1:0] hand;
   } scan_status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } scan_state_type;

   function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] h,
                                                  input logic [SIZE_W-1:0] n);
      logic [SIZE_W-1:0] nxt;
      nxt = SIZE_W'(h) + SIZE_W'(1);
      return (nxt >= n) ? '0 : nxt[SLOT_W-1:0];
   endfunction

endpackage

FILE: src/clock_page_replacement_core.sv
// write transaction: ring entry updated at the accepting edge
// victim request: m entries inspected one per cycle through the single-read-port
// ring memory; m is at most ring size + 1 (plain) or 3 x ring size + 1 (enhanced)
// one transaction in flight; a new one is taken while the previous result waits
// synchronous reset clears hand, control and config (plain mode, 64 frames); ring kept
module clock_page_replacement_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,  // slot, page_number, use_bit, dirty_bit
   input  logic                      req_tuser,  // mode
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata,  // victim_page, victim_slot, zero fill
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [cpr_pkg::CFG_W-1:0] csr_wdata
);
   import cpr_pkg::*;

   logic              enhanced_ff;
   logic [CFG_W-1:0]  frames_ff;
   logic [SIZE_W-1:0] ring_size;

   mem_req_type           mem_req;
   entry_type             mem_rdata;
   entry_type             req_entry;
   scan_status_type       status;
   logic [PAGE_WIDTH-1:0] rsp_page;
   logic [SLOT_W-1:0]     rsp_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         enhanced_ff <= 1'b0;
         frames_ff   <= CFG_W'(FRAMES);
      end else if (csr_we) begin
         case (csr_index)
            CFG_ENHANCED_MODE: enhanced_ff <= csr_wdata[0];
            CFG_FRAMES_IN_USE: frames_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, anything above the ring depth as the full ring
   always_comb begin
      if (frames_ff == '0) begin
         ring_size = SIZE_W'(1);
      end else if (frames_ff > CFG_W'(FRAMES)) begin
         ring_size = SIZE_W'(FRAMES);
      end else begin
         ring_size = SIZE_W'(frames_ff);
      end
   end

   assign req_entry.page      = req_tdata[SLOT_W +: PAGE_WIDTH];
   assign req_entry.use_bit   = req_tdata[SLOT_W + PAGE_WIDTH];
   assign req_entry.dirty_bit = req_tdata[SLOT_W + PAGE_WIDTH + 1];

   cpr_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .req_slot  (req_tdata[SLOT_W-1:0]),
      .req_entry (req_entry),
      .enhanced  (enhanced_ff),
      .ring_size (ring_size),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_page  (rsp_page),
      .rsp_slot  (rsp_slot),
      .status    (status)
   );

   cpr_ring u_ring (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   assign rsp_tdata = {(24 - PAGE_WIDTH - SLOT_W)'(0), rsp_slot, rsp_page};

   // no new transaction while the ring is being scanned
   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      status.scanning |-> !req_tready)
      else $error("transaction accepted during scan");

   // a victim request starts a scan on the next cycle
   a_victim_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == MODE_VICTIM) |=> status.scanning)
      else $error("victim request did not start a scan");

   // the scan only ever clears use bits
   a_scan_writes_clear: assert property (@(posedge clock) disable iff (reset)
      (status.scanning && mem_req.we) |-> !mem_req.wdata.use_bit)
      else $error("scan wrote a set use bit");

   // after a victim is chosen the hand lies inside the ring
   a_hand_in_ring: assert property (@(posedge clock) disable iff (reset)
      (!status.scanning && $past(status.scanning)) |-> (SIZE_W'(status.hand) < ring_size))
      else $error("hand outside ring after victim selection");

endmodule

FILE: src/cpr_ring.sv
module cpr_ring (
   input  logic                  clock,
   input  cpr_pkg::mem_req_type  mem_req,
   output cpr_pkg::entry_type    rdata
);
   import cpr_pkg::*;

   entry_type mem [FRAMES];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/cpr_scan.sv
module cpr_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [cpr_pkg::SLOT_W-1:0]    req_slot,
   input  cpr_pkg::entry_type            req_entry,
   input  logic                          enhanced,
   input  logic [cpr_pkg::SIZE_W-1:0]    ring_size,
   output cpr_pkg::mem_req_type          mem_req,
   input  cpr_pkg::entry_type            mem_rdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cpr_pkg::PAGE_WIDTH-1:0] rsp_page,
   output logic [cpr_pkg::SLOT_W-1:0]    rsp_slot,
   output cpr_pkg::scan_status_type      status
);
   import cpr_pkg::*;

   scan_state_type        state_ff, state_in;
   logic [SLOT_W-1:0]     hand_ff, hand_in;
   logic [SLOT_W-1:0]     iss_ff, iss_in;
   logic [SLOT_W-1:0]     ev_addr_ff, ev_addr_in;
   logic                  ev_vld_ff, ev_vld_in;
   logic [SLOT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]            sweep_ff, sweep_in;
   logic                  wr_vld_ff;
   logic [SLOT_W-1:0]     wr_addr_ff;
   entry_type             wr_data_ff;
   logic [PAGE_WIDTH-1:0] pend_page_ff, pend_page_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [PAGE_WIDTH-1:0] rsp_page_ff, rsp_page_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   entry_type ev_entry;
   logic      second;
   logic      hit;
   logic      clear_use;
   logic      accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE);

   // the entry written at the previous edge is not yet visible on the read port
   assign ev_entry = (wr_vld_ff && (wr_addr_ff == ev_addr_ff)) ? wr_data_ff : mem_rdata;
   assign second   = sweep_ff[0];

   always_comb begin
      if (enhanced) begin
         hit       = !ev_entry.use_bit && (ev_entry.dirty_bit == second);
         clear_use = second && !hit;
      end else begin
         hit       = !ev_entry.use_bit;
         clear_use = !hit;
      end
   end

   always_comb begin
      state_in     = state_ff;
      hand_in      = hand_ff;
      iss_in       = iss_ff;
      ev_addr_in   = ev_addr_ff;
      ev_vld_in    = ev_vld_ff;
      cnt_in       = cnt_ff;
      sweep_in     = sweep_ff;
      pend_page_in = pend_page_ff;
      pend_slot_in = pend_slot_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ready;
      rsp_page_in  = rsp_page_ff;
      rsp_slot_in  = rsp_slot_ff;

      mem_req.we    = 1'b0;
      mem_req.waddr = req_slot;
      mem_req.wdata = req_entry;
      mem_req.raddr = iss_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_WRITE) begin
                  mem_req.we = 1'b1;
               end else begin
                  iss_in    = (SIZE_W'(hand_ff) >= ring_size) ? '0 : hand_ff;
                  ev_vld_in = 1'b0;
                  cnt_in    = '0;
                  sweep_in  = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ev_vld_in  = 1'b1;
            ev_addr_in = iss_ff;
            iss_in     = advance(iss_ff, ring_size);
            if (ev_vld_ff) begin
               if (hit) begin
                  pend_page_in = ev_entry.page;
                  pend_slot_in = ev_addr_ff;
                  hand_in      = advance(ev_addr_ff, ring_size);
                  ev_vld_in    = 1'b0;
                  state_in     = ST_EMIT;
               end else begin
                  if (clear_use) begin
                     mem_req.we            = 1'b1;
                     mem_req.waddr         = ev_addr_ff;
                     mem_req.wdata         = ev_entry;
                     mem_req.wdata.use_bit = 1'b0;
                  end
                  if (SIZE_W'(cnt_ff) + SIZE_W'(1) >= ring_size) begin
                     cnt_in   = '0;
                     sweep_in = sweep_ff + 2'd1;
                  end else begin
                     cnt_in = cnt_ff + SLOT_W'(1);
                  end
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_vld_in  = 1'b1;
               rsp_page_in = pend_page_ff;
               rsp_slot_in = pend_slot_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         hand_ff    <= '0;
         ev_vld_ff  <= 1'b0;
         wr_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         hand_ff    <= hand_in;
         ev_vld_ff  <= ev_vld_in;
         wr_vld_ff  <= mem_req.we;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff       <= iss_in;
      ev_addr_ff   <= ev_addr_in;
      cnt_ff       <= cnt_in;
      sweep_ff     <= sweep_in;
      wr_addr_ff   <= mem_req.waddr;
      wr_data_ff   <= mem_req.wdata;
      pend_page_ff <= pend_page_in;
      pend_slot_ff <= pend_slot_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_page  = rsp_page_ff;
   assign rsp_slot  = rsp_slot_ff;

   assign status.idle     = (state_ff == ST_IDLE);
   assign status.scanning = (state_ff == ST_SCAN);
   assign status.hand     = hand_ff;

endmodule

FILE: tb/sv/clock_page_replacement_checker.sv
`timescale 1ns / 100ps

module clock_page_replacement_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [23:0]               req_tdata,  // slot, page_number, use_bit, dirty_bit
   input  logic                      req_tuser,  // mode
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [23:0]               rsp_tdata,  // victim_page, victim_slot, zero fill
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [cpr_pkg::CFG_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);
   import cpr_pkg::*;

   typedef struct packed {
      logic [PAGE_WIDTH-1:0] page;
      logic [SLOT_W-1:0]     slot;
   } victim_type;

   logic [PAGE_WIDTH-1:0] ring_page [FRAMES];
   logic                  ring_use [FRAMES];
   logic                  ring_dirty [FRAMES];
   int                    hand;
   logic                  enhanced;
   logic [CFG_W-1:0]      frames_cfg;
   victim_type            victims_due [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      hand          = 0;
      enhanced      = 1'b0;
      frames_cfg    = CFG_W'(FRAMES);
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // a ring size of zero behaves as one, anything above the store as the whole store
   function automatic int ring_span();
      int n;
      n = int'(frames_cfg);
      if (n == 0) n = 1;
      if (n > FRAMES) n = FRAMES;
      return n;
   endfunction

   function automatic int next_slot(input int h, input int n);
      return (h + 1 >= n) ? 0 : h + 1;
   endfunction

   task automatic choose_victim(output int v);
      int   n;
      int   h;
      int   sweep;
      int   k;
      logic found;
      logic second;
      n     = ring_span();
      h     = (hand >= n) ? 0 : hand;
      found = 1'b0;
      if (!enhanced) begin
         for (k = 0; k < n && !found; k++) begin
            if (!ring_use[h]) begin
               found = 1'b1;
            end else begin
               ring_use[h] = 1'b0;
               h = next_slot(h, n);
            end
         end
      end else begin
         // even sweeps look for clean and unused, odd sweeps for dirty and unused
         for (sweep = 0; sweep < 4 && !found; sweep++) begin
            second = sweep[0];
            for (k = 0; k < n && !found; k++) begin
               if (!ring_use[h] && ring_dirty[h] == second) begin
                  found = 1'b1;
               end else begin
                  if (second) ring_use[h] = 1'b0;
                  h = next_slot(h, n);
               end
            end
         end
      end
      v    = h;
      hand = next_slot(h, n);
   endtask

   always @(posedge clock) begin
      victim_type        want;
      int                v;
      logic [SLOT_W-1:0] s;
      if (reset) begin
         hand       = 0;
         enhanced   = 1'b0;
         frames_cfg = CFG_W'(FRAMES);
         victims_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (victims_due.size() == 0) begin
               report_mismatch($sformatf("result %h with no request waiting", rsp_tdata));
            end else begin
               want = victims_due.pop_front();
               if (rsp_tdata[PAGE_WIDTH-1:0] !== want.page)
                  report_mismatch($sformatf("victim_page %h, expected %h",
                                            rsp_tdata[PAGE_WIDTH-1:0], want.page));
               if (rsp_tdata[PAGE_WIDTH +: SLOT_W] !== want.slot)
                  report_mismatch($sformatf("victim_slot %0d, expected %0d",
                                            rsp_tdata[PAGE_WIDTH +: SLOT_W], want.slot));
            end
         end
         if (csr_we) begin
            if (csr_index == CFG_ENHANCED_MODE)
               enhanced = csr_wdata[0];
            else if (csr_index == CFG_FRAMES_IN_USE)
               frames_cfg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == MODE_WRITE) begin
               s             = req_tdata[SLOT_W-1:0];
               ring_page[s]  = req_tdata[SLOT_W +: PAGE_WIDTH];
               ring_use[s]   = req_tdata[SLOT_W + PAGE_WIDTH];
               ring_dirty[s] = req_tdata[SLOT_W + PAGE_WIDTH + 1];
            end else begin
               choose_victim(v);
               want.page = ring_page[v];
               want.slot = SLOT_W'(v);
               victims_due.push_back(want);
            end
         end
      end
      pending_count = victims_due.size();
   end

endmodule

FILE: tb/sv/clock_page_replacement_core_test.sv
`timescale 1ns / 100ps

module clock_page_replacement_core_test;
   import cpr_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 300;   // outlasts the longest victim scan
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_ITEMS = 125;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata  = '0;
   logic                  req_tuser  = MODE_WRITE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = CFG_ENHANCED_MODE;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   int fail_count;
   int pending_count;
   int send_idle_pct = 36;
   int recv_idle_pct = 66;
   int hold_requests = 0;
   int holds_done    = 0;
   int hold_left     = 0;
   int cycles        = 0;

   always #10 clock = ~clock;

   clock_page_replacement_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   clock_page_replacement_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // result side: random back-pressure, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_done < hold_requests) begin
         rsp_tready <= 1'b0;
         holds_done <= holds_done + 1;
         hold_left  <= LONG_HOLD;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_item(input logic mode, input logic [SLOT_W-1:0] slot,
                            input logic [PAGE_WIDTH-1:0] page, input logic use_b,
                            input logic dirty_b);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {dirty_b, use_b, page, slot};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_entry(input int slot, input int page, input logic use_b,
                              input logic dirty_b);
      send_item(MODE_WRITE, SLOT_W'(slot), PAGE_WIDTH'(page), use_b, dirty_b);
   endtask

   // the other fields are don't-care on a victim request, so keep them moving
   task automatic request_victim();
      send_item(MODE_VICTIM, SLOT_W'($urandom), PAGE_WIDTH'($urandom),
                1'($urandom), 1'($urandom));
   endtask

   // registers change only once the ring has gone quiet
   task automatic set_config(input logic enh, input int frames);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CFG_ENHANCED_MODE;
      csr_wdata <= CFG_W'(enh);
      @(negedge clock);
      csr_index <= CFG_FRAMES_IN_USE;
      csr_wdata <= CFG_W'(frames);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int   regime;
      int   p;
      int   i;
      int   r;
      int   frames;
      int   span;
      logic enh;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // load the whole ring so that no scan ever meets an unwritten entry
      for (i = 0; i < FRAMES; i++)
         write_entry(i, $urandom_range(0, 65535), 1'($urandom), 1'($urandom));

      // plain clock over four entries
      set_config(1'b0, 4);
      write_entry(0, 16'hffff, 1'b1, 1'b0);
      write_entry(1, 16'h0001, 1'b1, 1'b0);
      write_entry(2, 16'h0000, 1'b0, 1'b0);
      write_entry(3, 16'h8000, 1'b1, 1'b1);
      request_victim();
      request_victim();
      // every use bit set: a full sweep of second chances
      for (i = 0; i < 4; i++) write_entry(i, 16'hffff - i, 1'b1, 1'b0);
      request_victim();

      // enhanced clock: dirty and unused found in the second sweep
      set_config(1'b1, 4);
      write_entry(0, 16'h1234, 1'b1, 1'b1);
      write_entry(1, 16'hfffe, 1'b0, 1'b1);
      write_entry(2, 16'h00ff, 1'b1, 1'b0);
      write_entry(3, 16'hff00, 1'b1, 1'b1);
      request_victim();
      // all used and dirty: needs all four sweeps
      for (i = 0; i < 4; i++) write_entry(i, 16'h0f0f + i, 1'b1, 1'b1);
      request_victim();

      // ring size zero, then above the store, then hand beyond a shrunk ring
      set_config(1'b1, 0);
      request_victim();
      set_config(1'b0, 127);
      request_victim();
      request_victim();
      set_config(1'b0, 1);
      request_victim();

      for (regime = 0; regime < 3; regime++) begin
         send_idle_pct = (regime == 0) ? 36 : (regime == 1) ? 66 : 0;
         recv_idle_pct = (regime == 0) ? 66 : (regime == 1) ? 36 : 0;
         for (p = 0; p < 4; p++) begin
            enh = 1'($urandom);
            r   = $urandom_range(0, 9);
            if (r < 6)       frames = $urandom_range(1, 8);
            else if (r < 8)  frames = $urandom_range(9, 32);
            else if (r == 8) frames = $urandom_range(33, 64);
            else             frames = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(65, 127);
            if (regime * 4 + p == 1) begin
               enh    = 1'b1;
               frames = 64;
            end else if (regime * 4 + p == 5) begin
               enh    = 1'b0;
               frames = 64;
            end
            set_config(enh, frames);
            span = (frames == 0) ? 1 : (frames > FRAMES) ? FRAMES : frames;
            if (regime == 2 && p == 1) hold_requests = hold_requests + 1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
               r = $urandom_range(0, 99);
               if (r < 40)
                  request_victim();
               else if (r < 90)
                  write_entry($urandom_range(0, span - 1), $urandom_range(0, 65535),
                              1'($urandom), 1'($urandom));
               else
                  write_entry($urandom_range(0, FRAMES - 1), $urandom_range(0, 65535),
                              1'($urandom), 1'($urandom));
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
